[sv/ngib_pkg.sv]
// shared types, constants and helpers of the nested group index builder
package ngib_pkg;

    // colour word field layout
    localparam int OUTER_SHIFT  = 36;
    localparam int OUTER_BITS   = 28;
    localparam int MIDDLE_SHIFT = 16;
    localparam int MIDDLE_BITS  = 20;
    localparam int INNER_SHIFT  = 0;
    localparam int INNER_BITS   = 16;

    // widths
    localparam int WORD_W = 64;
    localparam int CNT_W  = 40;
    localparam int KIND_W = 3;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTER_ON  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIDDLE_ON = 1'd1;

    // record kinds
    localparam logic [KIND_W-1:0] KIND_OCC    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_OUTER  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MIDDLE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_INNER  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 3'd4;

    // saturation limit of the record counters
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef logic [CNT_W-1:0] t_cnt;

    // input item
    typedef struct packed {
        logic              action;
        logic [WORD_W-1:0] occupancy;
        logic [WORD_W-1:0] colors;
    } t_item;

    // result item
    typedef struct packed {
        logic [KIND_W-1:0] record_kind;
        logic [WORD_W-1:0] pattern;
        logic [CNT_W-1:0]  offset;
        logic [CNT_W-1:0]  count;
        logic              repeat_flag;
        logic              last;
    } t_result;

    // level enables
    typedef struct packed {
        logic outer_on;
        logic middle_on;
    } t_cfg;

    // classified item handed from front to back
    typedef struct packed {
        logic                   finish;
        logic                   err;
        logic [WORD_W-1:0]      err_pat;
        logic [WORD_W-1:0]      occ;
        logic [OUTER_BITS-1:0]  op;
        logic [MIDDLE_BITS-1:0] mp;
        logic [INNER_BITS-1:0]  ip;
    } t_work;

    // saturating increment
    function automatic t_cnt sat_inc(input t_cnt v);
        t_cnt r;
        r = (v == CNT_MAX) ? CNT_MAX : v + t_cnt'(1);
        return r;
    endfunction

endpackage

[sv/ngib_front.sv]
// front end: level enable registers and item classification
module ngib_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ngib_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ngib_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_push,
    input  ngib_pkg::t_item                   i_item,
    output logic                              o_full,
    input  logic                              i_q_full,
    output logic                              o_q_wr,
    output ngib_pkg::t_work                   o_work,
    output ngib_pkg::t_cfg                    o_cfg
);

    ngib_pkg::t_cfg r_cfg;

    logic [ngib_pkg::OUTER_BITS-1:0]  op;
    logic [ngib_pkg::MIDDLE_BITS-1:0] mp;
    logic [ngib_pkg::INNER_BITS-1:0]  ip;

    // level enable registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.outer_on  <= 1'b1;
            r_cfg.middle_on <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ngib_pkg::CFG_OUTER_ON:  r_cfg.outer_on  <= i_cfg_data[0];
                ngib_pkg::CFG_MIDDLE_ON: r_cfg.middle_on <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // split the colour word into ring fields
    always_comb begin
        op = ngib_pkg::OUTER_BITS'(i_item.colors >> ngib_pkg::OUTER_SHIFT);
        mp = ngib_pkg::MIDDLE_BITS'(i_item.colors >> ngib_pkg::MIDDLE_SHIFT);
        ip = ngib_pkg::INNER_BITS'(i_item.colors >> ngib_pkg::INNER_SHIFT);
    end

    // classify: finish, error on a skipped level, or plain key
    always_comb begin
        o_work.finish  = i_item.action;
        o_work.err     = 1'b0;
        o_work.err_pat = '0;
        o_work.occ     = i_item.occupancy;
        o_work.op      = op;
        o_work.mp      = mp;
        o_work.ip      = ip;
        if (!i_item.action) begin
            if (!r_cfg.outer_on && (op != '0)) begin
                o_work.err     = 1'b1;
                o_work.err_pat = ngib_pkg::WORD_W'(op);
            end else if (!r_cfg.middle_on && (mp != '0)) begin
                o_work.err     = 1'b1;
                o_work.err_pat = ngib_pkg::WORD_W'(mp);
            end
        end
    end

    // handshake towards the queue
    assign o_full = i_q_full;
    assign o_q_wr = i_push && !i_q_full;
    assign o_cfg  = r_cfg;

endmodule

[sv/ngib_queue.sv]
// short queue of classified items between front and back
module ngib_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  ngib_pkg::t_work i_wr_data,
    output logic            o_full,
    input  logic            i_rd,
    output ngib_pkg::t_work o_rd_data,
    output logic            o_empty
);

    localparam int AW = (ngib_pkg::QUEUE_DEPTH > 1) ? $clog2(ngib_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(ngib_pkg::QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(ngib_pkg::QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(ngib_pkg::QUEUE_DEPTH);

    ngib_pkg::t_work r_mem [ngib_pkg::QUEUE_DEPTH];
    logic [AW-1:0]   r_wptr;
    logic [AW-1:0]   r_rptr;
    logic [CW-1:0]   r_count;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) begin
                r_wptr <= (r_wptr == LAST_IDX) ? '0 : r_wptr + AW'(1);
            end
            if (i_rd) begin
                r_rptr <= (r_rptr == LAST_IDX) ? '0 : r_rptr + AW'(1);
            end
            case ({i_wr, i_rd})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_full    = (r_count == DEPTH_C);
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rptr];

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("queue fill count beyond depth");

    a_no_read_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> (r_count != '0))
        else $error("queue read while empty");

    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> (r_count != DEPTH_C))
        else $error("queue write while full");
`endif

endmodule

[sv/ngib_back.sv]
// back end: group state, cascade of closes and record buffer
module ngib_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ngib_pkg::t_cfg    i_cfg,
    input  ngib_pkg::t_work   i_work,
    input  logic              i_q_empty,
    output logic              o_q_rd,
    output ngib_pkg::t_result o_result,
    output logic              o_empty,
    input  logic              i_pop
);

    // record slots, in emission order
    localparam int SLOT_INNER  = 0;
    localparam int SLOT_MIDDLE = 1;
    localparam int SLOT_OUTER  = 2;
    localparam int SLOT_OCC    = 3;
    localparam int SLOTS       = 4;

    // group state
    logic [ngib_pkg::WORD_W-1:0]      r_cur_occ;
    logic                             r_occ_valid;
    logic [ngib_pkg::OUTER_BITS-1:0]  r_outer_pat;
    logic                             r_outer_open;
    logic [ngib_pkg::MIDDLE_BITS-1:0] r_mid_pat;
    logic                             r_mid_open;
    logic [ngib_pkg::INNER_BITS-1:0]  r_inner_pat;
    logic                             r_inner_open;
    ngib_pkg::t_cnt                   r_inner_rep;
    ngib_pkg::t_cnt                   r_outer_start;
    ngib_pkg::t_cnt                   r_mid_start;
    ngib_pkg::t_cnt                   r_outer_recs;
    ngib_pkg::t_cnt                   r_mid_recs;
    ngib_pkg::t_cnt                   r_inner_recs;

    // record buffer
    ngib_pkg::t_result r_rec [SLOTS];
    logic [SLOTS-1:0]  r_pend;

    logic              key;
    logic              occ_chg;
    logic              outer_new;
    logic              mid_new;
    logic              inner_new;
    logic              call_outer;
    logic              call_mid;
    logic              call_inner;
    logic              emit_inner;
    logic              emit_mid;
    logic              emit_outer;
    logic              emit_occ;
    ngib_pkg::t_cnt    inner_recs1;
    ngib_pkg::t_cnt    mid_recs1;
    ngib_pkg::t_cnt    outer_recs1;
    ngib_pkg::t_cnt    mid_cnt;
    ngib_pkg::t_cnt    outer_cnt;
    ngib_pkg::t_cnt    occ_off;
    ngib_pkg::t_result rec_new [SLOTS];
    logic [SLOTS-1:0]  mask_new;
    logic              can_load;
    logic              load;
    logic              pop_ok;
    logic [1:0]        sel;

    // decide which groups close and open for the item at the queue head
    always_comb begin
        key       = !i_work.finish && !i_work.err;
        occ_chg   = !r_occ_valid || (i_work.occ != r_cur_occ);
        outer_new = key && i_cfg.outer_on
                    && (occ_chg || !r_outer_open || (i_work.op != r_outer_pat));
        call_outer = i_work.finish || (key && occ_chg) || outer_new;
        mid_new   = key && i_cfg.middle_on
                    && (call_outer || !r_mid_open || (i_work.mp != r_mid_pat));
        call_mid  = call_outer || mid_new;
        inner_new = key && (call_mid || !r_inner_open || (i_work.ip != r_inner_pat));
        call_inner = call_mid || inner_new;

        emit_inner = call_inner && r_inner_open;
        emit_mid   = call_mid && i_cfg.middle_on && r_mid_open;
        emit_outer = call_outer && i_cfg.outer_on && r_outer_open;
        emit_occ   = key && occ_chg;
    end

    // record counters through the cascade, inner first
    always_comb begin
        inner_recs1 = emit_inner ? ngib_pkg::sat_inc(r_inner_recs) : r_inner_recs;
        mid_cnt     = inner_recs1 - r_mid_start;
        mid_recs1   = emit_mid ? ngib_pkg::sat_inc(r_mid_recs) : r_mid_recs;
        outer_cnt   = mid_recs1 - r_outer_start;
        outer_recs1 = emit_outer ? ngib_pkg::sat_inc(r_outer_recs) : r_outer_recs;
        if (i_cfg.outer_on) begin
            occ_off = outer_recs1;
        end else if (i_cfg.middle_on) begin
            occ_off = mid_recs1;
        end else begin
            occ_off = inner_recs1;
        end
    end

    // build the records of this item
    always_comb begin
        rec_new[SLOT_INNER].record_kind = ngib_pkg::KIND_INNER;
        rec_new[SLOT_INNER].pattern     = ngib_pkg::WORD_W'(r_inner_pat);
        rec_new[SLOT_INNER].offset      = '0;
        rec_new[SLOT_INNER].count       = '0;
        rec_new[SLOT_INNER].repeat_flag = (r_inner_rep != ngib_pkg::t_cnt'(1));
        rec_new[SLOT_INNER].last        = 1'b0;
        if (i_work.err) begin
            rec_new[SLOT_INNER].record_kind = ngib_pkg::KIND_ERROR;
            rec_new[SLOT_INNER].pattern     = i_work.err_pat;
            rec_new[SLOT_INNER].repeat_flag = 1'b0;
        end

        rec_new[SLOT_MIDDLE].record_kind = ngib_pkg::KIND_MIDDLE;
        rec_new[SLOT_MIDDLE].pattern     = ngib_pkg::WORD_W'(r_mid_pat);
        rec_new[SLOT_MIDDLE].offset      = r_mid_start;
        rec_new[SLOT_MIDDLE].count       = mid_cnt;
        rec_new[SLOT_MIDDLE].repeat_flag = 1'b0;
        rec_new[SLOT_MIDDLE].last        = 1'b0;

        rec_new[SLOT_OUTER].record_kind = ngib_pkg::KIND_OUTER;
        rec_new[SLOT_OUTER].pattern     = ngib_pkg::WORD_W'(r_outer_pat);
        rec_new[SLOT_OUTER].offset      = r_outer_start;
        rec_new[SLOT_OUTER].count       = outer_cnt;
        rec_new[SLOT_OUTER].repeat_flag = 1'b0;
        rec_new[SLOT_OUTER].last        = 1'b0;

        rec_new[SLOT_OCC].record_kind = ngib_pkg::KIND_OCC;
        rec_new[SLOT_OCC].pattern     = i_work.occ;
        rec_new[SLOT_OCC].offset      = occ_off;
        rec_new[SLOT_OCC].count       = '0;
        rec_new[SLOT_OCC].repeat_flag = 1'b0;
        rec_new[SLOT_OCC].last        = 1'b0;

        if (i_work.err) begin
            mask_new = 4'b0001;
        end else begin
            mask_new = {emit_occ, emit_outer, emit_mid, emit_inner};
        end
    end

    // take the next item once the buffer is empty or giving up its final record
    assign pop_ok   = i_pop && (r_pend != '0);
    assign can_load = (r_pend == '0) || (pop_ok && $onehot(r_pend));
    assign load     = can_load && !i_q_empty;
    assign o_q_rd   = load;

    // group state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_occ     <= '0;
            r_occ_valid   <= 1'b0;
            r_outer_pat   <= '0;
            r_outer_open  <= 1'b0;
            r_mid_pat     <= '0;
            r_mid_open    <= 1'b0;
            r_inner_pat   <= '0;
            r_inner_open  <= 1'b0;
            r_inner_rep   <= '0;
            r_outer_start <= '0;
            r_mid_start   <= '0;
            r_outer_recs  <= '0;
            r_mid_recs    <= '0;
            r_inner_recs  <= '0;
        end else if (load && !i_work.err) begin
            r_inner_recs <= inner_recs1;
            r_mid_recs   <= mid_recs1;
            r_outer_recs <= outer_recs1;
            if (emit_occ) begin
                r_cur_occ   <= i_work.occ;
                r_occ_valid <= 1'b1;
            end
            if (outer_new) begin
                r_outer_pat   <= i_work.op;
                r_outer_start <= mid_recs1;
                r_outer_open  <= 1'b1;
            end else if (emit_outer) begin
                r_outer_open <= 1'b0;
            end
            if (mid_new) begin
                r_mid_pat   <= i_work.mp;
                r_mid_start <= inner_recs1;
                r_mid_open  <= 1'b1;
            end else if (emit_mid) begin
                r_mid_open <= 1'b0;
            end
            if (key) begin
                r_inner_open <= 1'b1;
                if (inner_new) begin
                    r_inner_pat <= i_work.ip;
                    r_inner_rep <= ngib_pkg::t_cnt'(1);
                end else begin
                    r_inner_rep <= ngib_pkg::sat_inc(r_inner_rep);
                end
            end else begin
                r_inner_open <= 1'b0;
            end
        end
    end

    // record buffer payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int s = 0; s < SLOTS; s++) begin
                r_rec[s] <= rec_new[s];
            end
        end
    end

    // pending mask: load a new set, or drop the lowest record on pop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (load) begin
            r_pend <= mask_new;
        end else if (pop_ok) begin
            r_pend <= r_pend & (r_pend - SLOTS'(1));
        end
    end

    // oldest pending record goes out
    always_comb begin
        if (r_pend[SLOT_INNER]) begin
            sel = 2'(SLOT_INNER);
        end else if (r_pend[SLOT_MIDDLE]) begin
            sel = 2'(SLOT_MIDDLE);
        end else if (r_pend[SLOT_OUTER]) begin
            sel = 2'(SLOT_OUTER);
        end else begin
            sel = 2'(SLOT_OCC);
        end
        o_result      = r_rec[sel];
        o_result.last = $onehot(r_pend);
    end

    assign o_empty = (r_pend == '0);

`ifndef SYNTHESIS
    a_error_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend[SLOT_INNER] && (r_rec[SLOT_INNER].record_kind == ngib_pkg::KIND_ERROR))
        |-> (r_pend == 4'b0001))
        else $error("error record shares an item with other records");

    a_occ_entry_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend[SLOT_OCC] |-> r_occ_valid)
        else $error("occupancy entry pending without valid occupancy");

    a_finish_closes_inner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && i_work.finish) |=> !r_inner_open)
        else $error("inner group still open after finish");
`endif

endmodule

[sv/nested_group_index_builder_unit.sv]
// top level of the nested group index builder
//
//  channel   direction  handshake              payload
//  input     in         push / full            i_item   (ngib_pkg::t_item)
//  result    out        empty / pop            o_result (ngib_pkg::t_result)
//  config    in         i_cfg_we, i_cfg_idx    i_cfg_data
//
// An item that causes at most one record is taken every cycle while pop is
// high; one causing more (up to four) holds the back end until its last
// record is popped, as the buffer gives one record per cycle of pop.
// A two-entry queue lets the front keep accepting while the back drains.
// Reset is synchronous and active low; it closes all groups, clears the
// counters and sets both level enables.
module nested_group_index_builder_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ngib_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ngib_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            push,
    output logic                            full,
    input  ngib_pkg::t_item                 i_item,
    output logic                            empty,
    input  logic                            pop,
    output ngib_pkg::t_result               o_result
);

    logic            q_wr;
    logic            q_full;
    logic            q_rd;
    logic            q_empty;
    ngib_pkg::t_work wr_work;
    ngib_pkg::t_work rd_work;
    ngib_pkg::t_cfg  cfg;

    // accept and classify
    ngib_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .i_item     (i_item),
        .o_full     (full),
        .i_q_full   (q_full),
        .o_q_wr     (q_wr),
        .o_work     (wr_work),
        .o_cfg      (cfg)
    );

    // decoupling queue
    ngib_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (q_wr),
        .i_wr_data (wr_work),
        .o_full    (q_full),
        .i_rd      (q_rd),
        .o_rd_data (rd_work),
        .o_empty   (q_empty)
    );

    // group state and record output
    ngib_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_work    (rd_work),
        .i_q_empty (q_empty),
        .o_q_rd    (q_rd),
        .o_result  (o_result),
        .o_empty   (empty),
        .i_pop     (pop)
    );

endmodule

[tb/sv/tb.sv]
// testbench of the nested group index builder: random sorted key runs checked against a predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ngib_pkg::*;

    localparam int RECORDS_PER_ITEM = 4;
    localparam int DRAIN_CYCLES     = 24;
    localparam int HOLD_CYCLES      = 250;
    localparam int PHASE_ITEMS      = 60;
    localparam int PRINT_LIMIT      = 40;

    // block ports
    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = CFG_OUTER_ON;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  push       = 1'b0;
    logic                  full;
    t_item                 i_item     = '0;
    logic                  empty;
    logic                  pop        = 1'b0;
    t_result               o_result;

    nested_group_index_builder_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result)
    );

    // keys waiting to be offered, and records the block still owes
    t_item   key_queue[$];
    t_result expected_records[$];
    t_result step_records[$];

    // level enables as last written
    logic lvl_outer_on  = 1'b1;
    logic lvl_middle_on = 1'b1;

    // predictor copy of the index state
    logic [WORD_W-1:0]      cur_occ;
    logic                   occ_seen;
    logic [OUTER_BITS-1:0]  outer_pat;
    logic                   outer_live;
    logic [MIDDLE_BITS-1:0] middle_pat;
    logic                   middle_live;
    logic [INNER_BITS-1:0]  inner_pat;
    logic                   inner_live;
    t_cnt                   inner_hits;
    t_cnt                   outer_first;
    t_cnt                   middle_first;
    t_cnt                   outer_total;
    t_cnt                   middle_total;
    t_cnt                   inner_total;

    // run bookkeeping
    int mismatches      = 0;
    int items_sent      = 0;
    int records_checked = 0;
    int settings_used   = 0;
    int kind_seen[5]    = '{default: 0};

    // receiver hold-off, requested once by the sequence
    logic hold_go    = 1'b0;
    logic hold_taken = 1'b0;
    int   hold_left  = 0;

    // sender burst and receiver pattern state
    int gap_left   = 0;
    int burst_left = 1;
    int rx_mode    = 0;
    int rx_span    = 0;

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("record %0d %s: got %h, want %h",
                                      records_checked, name, got, want));
    endtask

    // saturating counter step
    function automatic t_cnt bump(t_cnt v);
        return (v == '1) ? v : v + t_cnt'(1);
    endfunction

    // one record of the current item, at most four per item
    function automatic void add_record(logic [KIND_W-1:0] kind, logic [63:0] pat,
                                       t_cnt off, t_cnt cnt, logic rep);
        t_result r;
        if (step_records.size() >= RECORDS_PER_ITEM) return;
        r.record_kind = kind;
        r.pattern     = pat;
        r.offset      = off;
        r.count       = cnt;
        r.repeat_flag = rep;
        r.last        = 1'b0;
        step_records.insert(step_records.size(), r);
    endfunction

    // group closing, inner first
    function automatic void close_inner_run();
        if (!inner_live) return;
        add_record(KIND_INNER, 64'(inner_pat), '0, '0, inner_hits != t_cnt'(1));
        inner_total = bump(inner_total);
        inner_live  = 1'b0;
    endfunction

    function automatic void close_middle_run();
        close_inner_run();
        if (!lvl_middle_on || !middle_live) return;
        add_record(KIND_MIDDLE, 64'(middle_pat), middle_first,
                   inner_total - middle_first, 1'b0);
        middle_total = bump(middle_total);
        middle_live  = 1'b0;
    endfunction

    function automatic void close_outer_run();
        close_middle_run();
        if (!lvl_outer_on || !outer_live) return;
        add_record(KIND_OUTER, 64'(outer_pat), outer_first,
                   middle_total - outer_first, 1'b0);
        outer_total = bump(outer_total);
        outer_live  = 1'b0;
    endfunction

    // records caused by one accepted item, appended to the expected list
    function automatic void predict_records(t_item it);
        logic [OUTER_BITS-1:0]  op;
        logic [MIDDLE_BITS-1:0] mp;
        logic [INNER_BITS-1:0]  ip;
        t_cnt                   next_off;
        t_result                r;
        step_records.delete();
        op = it.colors[OUTER_SHIFT +: OUTER_BITS];
        mp = it.colors[MIDDLE_SHIFT +: MIDDLE_BITS];
        ip = it.colors[INNER_SHIFT +: INNER_BITS];
        if (it.action) begin
            close_outer_run();
        end else if (!lvl_outer_on && op != '0) begin
            add_record(KIND_ERROR, 64'(op), '0, '0, 1'b0);
        end else if (!lvl_middle_on && mp != '0) begin
            add_record(KIND_ERROR, 64'(mp), '0, '0, 1'b0);
        end else begin
            // new occupancy closes everything and points at the top level
            if (!occ_seen || it.occupancy != cur_occ) begin
                close_outer_run();
                next_off = lvl_outer_on ? outer_total :
                           lvl_middle_on ? middle_total : inner_total;
                add_record(KIND_OCC, it.occupancy, next_off, '0, 1'b0);
                cur_occ  = it.occupancy;
                occ_seen = 1'b1;
            end
            if (lvl_outer_on && (!outer_live || op != outer_pat)) begin
                close_outer_run();
                outer_pat   = op;
                outer_first = middle_total;
                outer_live  = 1'b1;
            end
            if (lvl_middle_on && (!middle_live || mp != middle_pat)) begin
                close_middle_run();
                middle_pat   = mp;
                middle_first = inner_total;
                middle_live  = 1'b1;
            end
            if (!inner_live || ip != inner_pat) begin
                close_inner_run();
                inner_pat  = ip;
                inner_hits = '0;
                inner_live = 1'b1;
            end
            inner_hits = bump(inner_hits);
        end
        for (int i = 0; i < step_records.size(); i++) begin
            r      = step_records[i];
            r.last = (i == step_records.size() - 1);
            expected_records.insert(expected_records.size(), r);
        end
    endfunction

    // sender: bursts of items with random gaps
    always @(posedge i_clk) begin : driver
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                predict_records(i_item);
                items_sent++;
            end
            // an offered item stays until taken
            if (!(push && full)) begin
                if (gap_left != 0) begin
                    gap_left--;
                    push <= 1'b0;
                end else if (key_queue.size() != 0) begin
                    push   <= 1'b1;
                    i_item <= key_queue.pop_front();
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                                : $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin : holdoff
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_go && !hold_taken) begin
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver: checks each popped record, stalls on a changing pattern
    always @(posedge i_clk) begin : monitor
        t_result want;
        logic    go;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_records.size() == 0) begin
                    report_mismatch($sformatf("record with no item behind it, kind %0d",
                                              o_result.record_kind));
                end else begin
                    want = expected_records.pop_front();
                    check_field("kind", 64'(o_result.record_kind), 64'(want.record_kind));
                    check_field("pattern", o_result.pattern, want.pattern);
                    check_field("offset", 64'(o_result.offset), 64'(want.offset));
                    check_field("count", 64'(o_result.count), 64'(want.count));
                    check_field("repeat", 64'(o_result.repeat_flag), 64'(want.repeat_flag));
                    check_field("last", 64'(o_result.last), 64'(want.last));
                    if (want.record_kind <= KIND_ERROR)
                        kind_seen[int'(want.record_kind)]++;
                    records_checked++;
                end
            end
            if (rx_span == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_span = $urandom_range(5, 60);
            end else begin
                rx_span--;
            end
            case (rx_mode)
                0:       go = 1'b1;
                1:       go = $urandom_range(0, 1) == 0;
                2:       go = $urandom_range(0, 3) == 0;
                default: go = $urandom_range(0, 7) != 0;
            endcase
            pop <= go && (hold_left == 0);
        end
    end

    function automatic logic [63:0] pack_colors(logic [63:0] op, logic [63:0] mp,
                                                logic [63:0] ip);
        return (op << OUTER_SHIFT) | (mp << MIDDLE_SHIFT) | (ip << INNER_SHIFT);
    endfunction

    function automatic logic [63:0] rand_field(int bits);
        logic [63:0] v;
        case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = '1;
            default: v = {$urandom, $urandom};
        endcase
        return (bits >= 64) ? v : v & ((64'd1 << bits) - 64'd1);
    endfunction

    // field of a level: free when enabled, mostly zero when skipped
    function automatic logic [63:0] level_field(logic on, int bits);
        if (on || $urandom_range(0, 9) == 0) return rand_field(bits);
        return '0;
    endfunction

    task automatic add_key(logic [63:0] occ, logic [63:0] col);
        t_item it;
        it.action    = 1'b0;
        it.occupancy = occ;
        it.colors    = col;
        key_queue.insert(key_queue.size(), it);
    endtask

    task automatic add_finish();
        t_item it;
        it.action    = 1'b1;
        it.occupancy = {$urandom, $urandom};
        it.colors    = {$urandom, $urandom};
        key_queue.insert(key_queue.size(), it);
    endtask

    // boards of nested runs: occupancy, then outer, middle and inner runs
    task automatic add_boards(int target);
        int          added;
        int          reps;
        logic [63:0] occ;
        logic [63:0] op;
        logic [63:0] mp;
        logic [63:0] ip;
        added = 0;
        occ   = '0;
        while (added < target) begin
            if (added == 0 || $urandom_range(0, 3) != 0) occ = rand_field(64);
            for (int a = 0; a < $urandom_range(1, 3); a++) begin
                op = level_field(lvl_outer_on, OUTER_BITS);
                for (int b = 0; b < $urandom_range(1, 3); b++) begin
                    mp = level_field(lvl_middle_on, MIDDLE_BITS);
                    for (int c = 0; c < $urandom_range(1, 3); c++) begin
                        ip   = rand_field(INNER_BITS);
                        reps = $urandom_range(1, 3);
                        for (int r = 0; r < reps; r++) begin
                            // occasional stray key out of order
                            if ($urandom_range(0, 19) == 0)
                                add_key({$urandom, $urandom}, {$urandom, $urandom});
                            else
                                add_key(occ, pack_colors(op, mp, ip));
                            added++;
                        end
                    end
                end
            end
            if ($urandom_range(0, 3) != 0) begin
                add_finish();
                added++;
            end
        end
    endtask

    // wait until every item is taken and every record has come back
    task automatic wait_drained();
        @(negedge i_clk);
        while (key_queue.size() != 0 || push || expected_records.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // write both level enables, block idle
    task automatic set_levels(logic outer_on, logic middle_on);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_OUTER_ON;
        i_cfg_data <= outer_on;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MIDDLE_ON;
        i_cfg_data <= middle_on;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        lvl_outer_on  = outer_on;
        lvl_middle_on = middle_on;
        settings_used++;
        @(negedge i_clk);
    endtask

    // overall timeout
    initial begin
        #(400000 * 12);
        $display("FAILURE");
        $finish;
    end

    // sequence
    initial begin
        cur_occ      = '0;
        occ_seen     = 1'b0;
        outer_pat    = '0;
        outer_live   = 1'b0;
        middle_pat   = '0;
        middle_live  = 1'b0;
        inner_pat    = '0;
        inner_live   = 1'b0;
        inner_hits   = '0;
        outer_first  = '0;
        middle_first = '0;
        outer_total  = '0;
        middle_total = '0;
        inner_total  = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        // all levels on: empty finish, repeats, each level changing, full cascade
        set_levels(1'b1, 1'b1);
        add_finish();
        add_key('0, '0);
        add_key('0, '0);
        add_key('0, pack_colors(0, 0, 64'hffff));
        add_key('0, pack_colors(0, 64'hfffff, 64'hffff));
        add_key('0, '1);
        add_key('1, '1);
        add_finish();
        add_finish();
        add_key({32{2'b01}}, {32{2'b10}});
        add_key({32{2'b01}}, {32{2'b01}});
        wait_drained();

        // outer skipped with its group still open
        set_levels(1'b0, 1'b1);
        add_key({32{2'b01}}, pack_colors(1, 0, 0));
        add_key({32{2'b01}}, pack_colors(0, 64'h12345, 7));
        add_key(64'd1, pack_colors(0, 64'h12345, 7));
        add_finish();
        wait_drained();

        // both skipped: middle error, outer error checked first, inner only
        set_levels(1'b0, 1'b0);
        add_key(64'd1, pack_colors(0, 64'h80000, 0));
        add_key(64'd1, pack_colors(64'h8000000, 64'h1, 0));
        add_key(64'd2, pack_colors(0, 0, 3));
        add_key(64'd2, pack_colors(0, 0, 4));
        wait_drained();

        // outer back on: the stale outer group comes out at finish
        set_levels(1'b1, 1'b1);
        add_finish();
        wait_drained();

        // random boards under each setting, long hold-off in the first
        set_levels(1'b1, 1'b1);
        add_boards(PHASE_ITEMS);
        hold_go <= 1'b1;
        wait_drained();
        set_levels(1'b1, 1'b0);
        add_boards(PHASE_ITEMS);
        wait_drained();
        set_levels(1'b0, 1'b1);
        add_boards(PHASE_ITEMS);
        wait_drained();
        set_levels(1'b0, 1'b0);
        add_boards(PHASE_ITEMS);
        wait_drained();
        set_levels(1'b1, 1'b1);
        add_boards(PHASE_ITEMS);
        add_finish();
        wait_drained();

        $display("%0d items in, %0d records checked, %0d level settings, %0d mismatches",
                 items_sent, records_checked, settings_used, mismatches);
        $display("records by kind: occupancy %0d, outer %0d, middle %0d, inner %0d, error %0d",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
